FILE: rtl/csc_pkg.sv
package csc_pkg;

  localparam int NUM_SENSORS = 16;
  localparam int SENS_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  // shared divider geometry: dividend covers (t - base) * 100
  localparam int DVD_W = 25;
  localparam int DVS_W = 16;
  localparam int CNT_W = $clog2(DVD_W + 1);

  // floor(s * 256 / 100) as (s * OFS_MUL) >> OFS_SHIFT, exact for any 16-bit s
  localparam int          OFS_SHIFT = 21;
  localparam int          OFS_W     = 18;
  localparam logic [22:0] OFS_MUL   = 23'd5368710;

  // op codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_RETARE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SCALE    = 3'd0;
  localparam logic [2:0] REG_CHANNELS = 3'd1;
  localparam logic [2:0] REG_AUTOGAIN = 3'd2;
  localparam logic [2:0] REG_INITGAIN = 3'd3;

  localparam logic [2:0]  GAIN_LOW  = 3'h1;
  localparam logic [2:0]  GAIN_HIGH = 3'h5;
  localparam logic [15:0] THR_LOW   = 16'h8000;
  localparam logic [15:0] THR_HIGH  = 16'hFEEE;
  localparam logic [15:0] PCT       = 16'd100;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/csc_div.sv
// Restoring divider, one quotient bit per cycle.
module csc_div (
  input  logic                clk,
  input  logic                rst,
  input  csc_pkg::div_req_t   req,
  output csc_pkg::div_rsp_t   rsp
);

  logic                       busy;
  logic                       done;
  logic [csc_pkg::CNT_W-1:0]  cnt;
  logic [csc_pkg::DVD_W-1:0]  dvd;
  logic [csc_pkg::DVS_W-1:0]  dvs;
  logic [csc_pkg::DVS_W-1:0]  rem;
  logic [csc_pkg::DVS_W:0]    rem_sh;
  logic [csc_pkg::DVS_W:0]    rem_next;
  logic                       ge;

  always_comb begin
    rem_sh   = {rem, dvd[csc_pkg::DVD_W-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == csc_pkg::CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= csc_pkg::CNT_W'(csc_pkg::DVD_W);
      end else if (busy) begin
        rem <= rem_next[csc_pkg::DVS_W-1:0];
        dvd <= {dvd[csc_pkg::DVD_W-2:0], ge};   // quotient shifts in from the bottom
        cnt <= cnt - 1'b1;
        if (cnt == csc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

FILE: rtl/capacitive_sample_conditioner.sv
// Capacitive sample conditioner.
// Input stream s_*: s_tuser carries the op (sample, load baseline, retare),
// s_tdata the sensor index, raw count, baseline value and time stamp.
// Output stream m_*: one transfer per sample op; m_tlast marks the sample
// that closes a frame. Load and retare ops produce no output transfer.
// Config port cfg_*: always ready, one register write per transfer; write
// only while no sample is in flight.
// The offset floor(scale*256/100) comes from a reciprocal multiply at accept,
// the next cycle compares raw + offset with the baseline, and a level above
// baseline then runs one shared 25-step restoring divider for
// (t - base)*100/scale before m_tvalid rises. At or below baseline the divide
// is skipped, the level is zero and m_tvalid rises without waiting on it.
// s_tready is low from the accept until the result is loaded, so the block
// takes no new sample while one is in flight. Load and retare ops leave
// s_tready high.
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver holds the block only when a second result is
// finished and the output register is still full.
// Reset (rst, synchronous) clears the baseline table, slot and frame
// counters, tare and gain-detect flags and restores register defaults.
module capacitive_sample_conditioner (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // sensor_index[3:0], raw_count[19:4],
                                 // baseline_value[35:20], time_stamp[51:36]
  input  logic [1:0]  s_tuser,   // op[1:0]
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // slot[3:0], level[19:4], frame_number[35:20],
                                 // stamp_out[51:36], gain_code[54:52]
  output logic        m_tlast,   // frame_done
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW  = csc_pkg::SENS_W;
  localparam int T_W = 19;   // raw + floor(scale*256/100) fits here

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_DIV, ST_FINISH} state_t;

  state_t state;

  // config registers
  logic [15:0] scale_factor;
  logic [4:0]  channels_per_frame;
  logic        auto_gain_enable;

  // block state
  logic [15:0] baseline_table [csc_pkg::NUM_SENSORS];
  logic [3:0]  slot_counter;
  logic [15:0] frame_counter;
  logic        tare_done;
  logic        gain_detected;
  logic [2:0]  gain_setting;

  // per-sample holding registers
  logic [15:0]              raw_q;
  logic [15:0]              base_q;
  logic [15:0]              scale_q;
  logic [csc_pkg::OFS_W-1:0] offset_q;
  logic [15:0]              stamp_q;
  logic [3:0]               slot_q;
  logic [15:0]              frame_q;
  logic [2:0]               gain_q;
  logic                     done_q;
  logic [15:0]              level_q;

  csc_pkg::div_req_t div_req;
  csc_pkg::div_rsp_t div_rsp;

  // input decode
  logic [1:0]     in_op;
  logic [3:0]     in_idx;
  logic [15:0]    in_raw;
  logic [15:0]    in_bval;
  logic [15:0]    in_stamp;
  logic [SW+3:0]  idx_ext;
  logic           in_range;
  logic [SW-1:0]  tidx;
  logic [15:0]    base_sel;
  logic           s_accept;
  logic           gain_run;
  logic [2:0]     gain_cur;
  logic [15:0]    thr;
  logic [15:0]    scale_eff;
  logic [38:0]    ofs_prod;
  logic [4:0]     limit;
  logic [4:0]     slot_nxt;
  logic           frame_end;
  logic [T_W-1:0] t_sum;
  logic           lvl_go;
  logic [T_W-1:0] diff;
  logic [csc_pkg::DVD_W-1:0] dext;
  logic [csc_pkg::DVD_W-1:0] prod;

  assign in_op    = s_tuser;
  assign in_idx   = s_tdata[3:0];
  assign in_raw   = s_tdata[19:4];
  assign in_bval  = s_tdata[35:20];
  assign in_stamp = s_tdata[51:36];

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    idx_ext  = {{SW{1'b0}}, in_idx};
    in_range = idx_ext < (SW+4)'(csc_pkg::NUM_SENSORS);
    tidx     = idx_ext[SW-1:0];
    // first sample after tare on sensor 0 reads back the raw count it just stored
    if (!tare_done && in_range && (tidx == '0)) begin
      base_sel = in_raw;
    end else if (in_range) begin
      base_sel = baseline_table[tidx];
    end else begin
      base_sel = '0;
    end

    gain_run = auto_gain_enable && !gain_detected;
    thr      = (gain_setting < 3'd2) ? csc_pkg::THR_LOW : csc_pkg::THR_HIGH;
    gain_cur = gain_run ? ((in_raw > thr) ? csc_pkg::GAIN_LOW : csc_pkg::GAIN_HIGH)
                        : gain_setting;

    scale_eff = (scale_factor == '0) ? 16'd1 : scale_factor;
    // offset floor(scale * 256 / 100) by reciprocal multiply
    ofs_prod  = 39'(scale_eff) * 39'(csc_pkg::OFS_MUL);

    if (channels_per_frame == '0) begin
      limit = 5'd1;
    end else if (channels_per_frame > 5'd16) begin
      limit = 5'd16;
    end else begin
      limit = channels_per_frame;
    end
    slot_nxt  = {1'b0, slot_counter} + 5'd1;
    frame_end = slot_nxt >= limit;

    // level numerator: (t - base) * 100 by shift-add
    t_sum  = T_W'(offset_q) + T_W'(raw_q);
    lvl_go = t_sum > T_W'(base_q);
    diff   = t_sum - T_W'(base_q);
    dext   = csc_pkg::DVD_W'(diff);
    prod   = (dext << 6) + (dext << 5) + (dext << 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      scale_factor       <= 16'd300;
      channels_per_frame <= 5'd1;
      auto_gain_enable   <= 1'b1;
      for (int i = 0; i < csc_pkg::NUM_SENSORS; i++) begin
        baseline_table[i] <= '0;
      end
      slot_counter  <= '0;
      frame_counter <= '0;
      tare_done     <= 1'b0;
      gain_detected <= 1'b0;
      gain_setting  <= 3'd1;
      div_req.start <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      div_req.start <= (state == ST_CMP) && lvl_go;
      if (m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          csc_pkg::REG_SCALE:    scale_factor       <= cfg_data;
          csc_pkg::REG_CHANNELS: channels_per_frame <= cfg_data[4:0];
          csc_pkg::REG_AUTOGAIN: auto_gain_enable   <= cfg_data[0];
          csc_pkg::REG_INITGAIN: gain_setting       <= cfg_data[2:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            unique case (in_op)
              csc_pkg::OP_LOAD: begin
                if (in_range) begin
                  baseline_table[tidx] <= in_bval;
                end
              end
              csc_pkg::OP_RETARE: begin
                tare_done <= 1'b0;
              end
              csc_pkg::OP_SAMPLE: begin
                if (gain_run) begin
                  gain_setting  <= gain_cur;
                  gain_detected <= 1'b1;
                end
                if (!tare_done) begin
                  baseline_table[0] <= in_raw;
                  tare_done         <= 1'b1;
                end
                raw_q    <= in_raw;
                base_q   <= base_sel;
                scale_q  <= scale_eff;
                offset_q <= ofs_prod[csc_pkg::OFS_SHIFT+csc_pkg::OFS_W-1:csc_pkg::OFS_SHIFT];
                stamp_q  <= in_stamp;
                slot_q   <= slot_counter;
                frame_q  <= frame_counter;
                gain_q   <= gain_cur;
                done_q   <= frame_end;
                if (frame_end) begin
                  frame_counter <= frame_counter + 16'd1;
                  slot_counter  <= '0;
                end else begin
                  slot_counter <= slot_nxt[3:0];
                end
                state <= ST_CMP;
              end
              default: ;   // unused op
            endcase
          end
        end
        ST_CMP: begin
          if (lvl_go) begin
            div_req.dividend <= prod;
            div_req.divisor  <= scale_q;
            state            <= ST_DIV;
          end else begin
            level_q <= '0;
            state   <= ST_FINISH;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            level_q <= div_rsp.quotient[15:0];
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, gain_q, stamp_q, frame_q, level_q, slot_q};
            m_tlast  <= done_q;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  csc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // a sample always goes on to the baseline compare
  a_sample_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (in_op == csc_pkg::OP_SAMPLE)) |=> (state == ST_CMP))
    else $error("sample accept did not reach baseline compare");

  // divider completions only arrive while the sequencer waits for them
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider done outside the divide state");

  // never restart the shared divider mid-run
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // frame counter moves only on a reset or an accepted item
  a_frame_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(frame_counter) |-> ($past(rst) || $past(s_accept)))
    else $error("frame counter changed without a transfer");

endmodule
